FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the date block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on an explicit clock and active-low reset.
`define GDA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("date block assertion failed");

// Assert a property on the standard clk_i / rst_ni pair.
`define GDA_ASSERT_STD(name, prop) `GDA_ASSERT(name, clk_i, rst_ni, prop)

`endif

FILE: hw/rtl/gda_pkg.sv
// Types, constants and calendar helpers of the Gregorian date block.
`timescale 1ns / 1ps
package gda_pkg;

  // Year counter spans years 0 to 16383.
  localparam int YearCntW = 14;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [15:0] day_count;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [11:0] other_year;
  } in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [11:0] result_year;
    logic [15:0] day_difference;
    logic        out_of_range;
  } out_t;

  // Commands from the sequencer to the calendar counter.
  typedef struct packed {
    logic init;
    logic year_step;
    logic month_step;
  } cal_cmd_t;

  // Status of the calendar counter.
  typedef struct packed {
    logic [YearCntW-1:0] year;
    logic [3:0]          month;
    logic                leap;
    logic [8:0]          year_len;
    logic [4:0]          month_len;
  } cal_sts_t;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Length of a month; zero for a code that is no month.
  function automatic logic [4:0] month_days(logic [3:0] mo, logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = mo - 4'd1;
    len = 5'd0;
    if (mo >= 4'd1 && mo <= 4'd12) begin
      len = MONTH_LEN[idx];
      if (mo == 4'd2 && leap) begin
        len = 5'd29;
      end
    end
    return len;
  endfunction

endpackage

FILE: hw/rtl/gda_cal.sv
// Calendar counter: steps year and month and tracks the leap rule by residues.
`timescale 1ns / 1ps
module gda_cal #(
  parameter int unsigned FIRST_YEAR = 1970
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gda_pkg::cal_cmd_t cmd_i,
  output gda_pkg::cal_sts_t sts_o
);
  import gda_pkg::*;

  localparam int Mod4   = FIRST_YEAR % 4;
  localparam int Mod100 = FIRST_YEAR % 100;
  localparam int Cent4  = (FIRST_YEAR / 100) % 4;

  logic [YearCntW-1:0] year_q;
  logic [3:0]          month_q;
  logic [1:0]          mod4_q;
  logic [6:0]          mod100_q;
  logic [1:0]          cent4_q;
  logic                leap;

  // Leap when divisible by 4, except centuries not divisible by 400.
  assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (cent4_q == 2'd0));

  // Step the counters on command; restart at 1.1.FIRST_YEAR on reset or init.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= YearCntW'(FIRST_YEAR);
      month_q  <= 4'd1;
      mod4_q   <= 2'(Mod4);
      mod100_q <= 7'(Mod100);
      cent4_q  <= 2'(Cent4);
    end else if (cmd_i.init) begin
      year_q   <= YearCntW'(FIRST_YEAR);
      month_q  <= 4'd1;
      mod4_q   <= 2'(Mod4);
      mod100_q <= 7'(Mod100);
      cent4_q  <= 2'(Cent4);
    end else begin
      if (cmd_i.year_step) begin
        year_q <= year_q + YearCntW'(1);
        mod4_q <= mod4_q + 2'd1;
        if (mod100_q == 7'd99) begin
          mod100_q <= 7'd0;
          cent4_q  <= cent4_q + 2'd1;
        end else begin
          mod100_q <= mod100_q + 7'd1;
        end
      end
      if (cmd_i.month_step) begin
        month_q <= month_q + 4'd1;
      end
    end
  end

  assign sts_o.year      = year_q;
  assign sts_o.month     = month_q;
  assign sts_o.leap      = leap;
  assign sts_o.year_len  = leap ? 9'd366 : 9'd365;
  assign sts_o.month_len = month_days(month_q, leap);

endmodule

FILE: hw/rtl/gregorian_date_arithmetic.sv
// Top level: Gregorian date add, subtract and difference on one shared adder.
//
//   channel | direction | payload | handshake
//   in      | input     | in_t    | in_valid_i / in_stall_o
//   out     | output    | out_t   | out_valid_o / out_stall_i
//
// One transaction at a time; the block stalls its input until the result
// has been taken. Each date is turned into a day number by stepping years,
// then months, through the shared adder; add and subtract then apply the day
// count (clamping at the range ends) and step the result back into a date,
// while difference converts both dates and subtracts the smaller number.
// Reset returns the sequencer to idle; no clearing pass is needed.
`timescale 1ns / 1ps
module gregorian_date_arithmetic #(
  parameter int unsigned FIRST_YEAR = 1970,
  parameter int unsigned LAST_YEAR  = 2099
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gda_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gda_pkg::out_t out_data_o
);
  import gda_pkg::*;

  // Day numbers counted from 1.1.FIRST_YEAR.
  localparam int PrevF   = FIRST_YEAR - 1;
  localparam int DaysF   = PrevF * 365 + PrevF / 4 - PrevF / 100 + PrevF / 400;
  localparam int DaysL   = LAST_YEAR * 365 + LAST_YEAR / 4 - LAST_YEAR / 100
                           + LAST_YEAR / 400;
  localparam int LastSer = (FIRST_YEAR > LAST_YEAR) ? 0 : DaysL - DaysF - 1;
  localparam int SerW    = $clog2(LastSer + 65536 + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CINIT,
    ST_CYEAR,
    ST_CDAY,
    ST_CMON,
    ST_CDONE,
    ST_ARITH,
    ST_CLAMP,
    ST_FINIT,
    ST_FYEAR,
    ST_FMON,
    ST_DIFF,
    ST_OUT
  } state_e;

  state_e          state_q;
  in_t             in_q;
  logic [SerW-1:0] acc_q;
  logic [SerW-1:0] aux_q;
  logic            sel_b_q;
  logic            swap_q;
  logic            flag_q;
  out_t            out_q;

  cal_cmd_t        cal_cmd;
  cal_sts_t        cal_sts;

  logic [4:0]      cur_day;
  logic [3:0]      cur_month;
  logic [11:0]     cur_year;
  logic [4:0]      cur_mlen;
  logic            cur_ok;

  logic [SerW-1:0] op_a;
  logic [SerW-1:0] op_b;
  logic            op_sub;
  logic [SerW:0]   unit_res;
  logic            borrow;

  gda_cal #(
    .FIRST_YEAR(FIRST_YEAR)
  ) u_cal (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cal_cmd),
    .sts_o (cal_sts)
  );

  // Pick the date under conversion.
  assign cur_day   = sel_b_q ? in_q.other_day   : in_q.day;
  assign cur_month = sel_b_q ? in_q.other_month : in_q.month;
  assign cur_year  = sel_b_q ? in_q.other_year  : in_q.year;
  assign cur_mlen  = month_days(cur_month, cal_sts.leap);
  assign cur_ok    = ({2'b00, cur_year} >= YearCntW'(FIRST_YEAR)) &&
                     ({2'b00, cur_year} <= YearCntW'(LAST_YEAR)) &&
                     (cur_month >= 4'd1) && (cur_month <= 4'd12);

  // Route operands into the shared adder.
  always_comb begin
    op_a   = acc_q;
    op_b   = '0;
    op_sub = 1'b0;
    case (state_q)
      ST_CYEAR: op_b = SerW'(cal_sts.year_len);
      ST_CMON: begin
        if (cal_sts.month == cur_month) begin
          op_b = SerW'(cur_day - 5'd1);
        end else begin
          op_b = SerW'(cal_sts.month_len);
        end
      end
      ST_ARITH: begin
        op_b   = SerW'(in_q.day_count);
        op_sub = (in_q.operation == OP_SUB);
      end
      ST_FYEAR: begin
        op_b   = SerW'(cal_sts.year_len);
        op_sub = 1'b1;
      end
      ST_FMON: begin
        op_b   = SerW'(cal_sts.month_len);
        op_sub = 1'b1;
      end
      ST_DIFF: begin
        op_a   = swap_q ? aux_q : acc_q;
        op_b   = swap_q ? acc_q : aux_q;
        op_sub = 1'b1;
      end
      default: begin
        op_b = '0;
      end
    endcase
  end

  assign unit_res = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
  assign borrow   = op_sub & unit_res[SerW];

  // Drive the calendar counter.
  always_comb begin
    cal_cmd = '0;
    case (state_q)
      ST_CINIT, ST_FINIT: cal_cmd.init = 1'b1;
      ST_CYEAR: cal_cmd.year_step = (cal_sts.year != {2'b00, cur_year});
      ST_CMON:  cal_cmd.month_step = (cal_sts.month != cur_month);
      ST_FYEAR: cal_cmd.year_step = !borrow && (cal_sts.year < YearCntW'(LAST_YEAR));
      ST_FMON:  cal_cmd.month_step = !borrow && (cal_sts.month < 4'd12);
      default:  cal_cmd = '0;
    endcase
  end

  // Sequence one transaction and hold the result until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      in_q    <= '0;
      acc_q   <= '0;
      aux_q   <= '0;
      sel_b_q <= 1'b0;
      swap_q  <= 1'b0;
      flag_q  <= 1'b0;
      out_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            sel_b_q <= 1'b0;
            swap_q  <= 1'b0;
            flag_q  <= 1'b0;
            out_q   <= '0;
            if (in_data_i.operation inside {OP_ADD, OP_SUB, OP_DIFF}) begin
              state_q <= ST_CINIT;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_CINIT: begin
          acc_q   <= '0;
          state_q <= cur_ok ? ST_CYEAR : ST_CDONE;
        end
        ST_CYEAR: begin
          if (cal_sts.year == {2'b00, cur_year}) begin
            state_q <= ST_CDAY;
          end else begin
            acc_q <= unit_res[SerW-1:0];
          end
        end
        ST_CDAY: begin
          if (cur_day == 5'd0 || cur_day > cur_mlen) begin
            acc_q   <= '0;
            state_q <= ST_CDONE;
          end else begin
            state_q <= ST_CMON;
          end
        end
        ST_CMON: begin
          acc_q <= unit_res[SerW-1:0];
          if (cal_sts.month == cur_month) begin
            state_q <= ST_CDONE;
          end
        end
        ST_CDONE: begin
          if (in_q.operation == OP_DIFF) begin
            if (!sel_b_q) begin
              aux_q   <= acc_q;
              sel_b_q <= 1'b1;
              state_q <= ST_CINIT;
            end else begin
              state_q <= ST_DIFF;
            end
          end else begin
            state_q <= ST_ARITH;
          end
        end
        ST_ARITH: begin
          if (borrow) begin
            acc_q  <= '0;
            flag_q <= 1'b1;
          end else begin
            acc_q <= unit_res[SerW-1:0];
          end
          state_q <= (in_q.operation == OP_ADD) ? ST_CLAMP : ST_FINIT;
        end
        ST_CLAMP: begin
          if (acc_q > SerW'(LastSer)) begin
            acc_q  <= SerW'(LastSer);
            flag_q <= 1'b1;
          end
          state_q <= ST_FINIT;
        end
        ST_FINIT: begin
          state_q <= ST_FYEAR;
        end
        ST_FYEAR: begin
          if (borrow || cal_sts.year >= YearCntW'(LAST_YEAR)) begin
            state_q <= ST_FMON;
          end else begin
            acc_q <= unit_res[SerW-1:0];
          end
        end
        ST_FMON: begin
          if (borrow || cal_sts.month >= 4'd12) begin
            out_q.result_day     <= acc_q[4:0] + 5'd1;
            out_q.result_month   <= cal_sts.month;
            out_q.result_year    <= cal_sts.year[11:0];
            out_q.day_difference <= '0;
            out_q.out_of_range   <= flag_q;
            state_q              <= ST_OUT;
          end else begin
            acc_q <= unit_res[SerW-1:0];
          end
        end
        ST_DIFF: begin
          // Date fields and flag were cleared when the transaction was taken.
          if (borrow) begin
            swap_q <= 1'b1;
          end else begin
            if (|unit_res[SerW-1:16]) begin
              out_q.day_difference <= 16'hFFFF;
            end else begin
              out_q.day_difference <= unit_res[15:0];
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/gda_chk.sv
// Port checker for the date block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gda_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gda_pkg::out_t out_data_o
);
  import gda_pkg::*;

  logic date_blank;
  logic diff_set;

  // Classify the offered result.
  assign date_blank = (out_data_o.result_day == 5'd0) && (out_data_o.result_month == 4'd0) &&
                      (out_data_o.result_year == 12'd0);
  assign diff_set   = (out_data_o.day_difference != 16'd0);

  // A stalled result stays offered and unchanged.
  `GDA_ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // No new transaction is taken while a result waits.
  `GDA_ASSERT_STD(a_busy_while_out, out_valid_o |-> in_stall_o)

  // A taken transaction keeps the input stalled on the next cycle.
  `GDA_ASSERT_STD(a_busy_after_take, in_valid_i && !in_stall_o |=> in_stall_o)

  // A nonzero difference carries no date and no range flag.
  `GDA_ASSERT_STD(a_diff_clean, out_valid_o && diff_set |-> date_blank && !out_data_o.out_of_range)

  // A clamped result is a real date with no difference.
  `GDA_ASSERT_STD(a_clamp_date, out_valid_o && out_data_o.out_of_range |-> !diff_set && !date_blank)

endmodule

bind gregorian_date_arithmetic gda_chk u_gda_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

FILE: tb/gregorian_date_arithmetic_tb.sv
// Self-checking testbench of the Gregorian date add, subtract and difference block.
`timescale 1ns / 1ps
module gregorian_date_arithmetic_tb;
  import gda_pkg::*;

  localparam int FirstYear   = 1970;
  localparam int LastYear    = 2099;
  localparam int LastSerial  = 47481;   // day number of 31.12.LastYear
  localparam int DiffCeiling = 65535;
  localparam int QuietLimit  = 3000;    // cycles without any transaction
  localparam int TailCycles  = 400;     // idle cycles after the last result
  localparam int RandomItems = 1300;
  localparam int ReportLimit = 10;
  localparam logic [1:0] OpUnused = 2'd3;

  // Expected date results, computed from calendar arithmetic on day numbers.
  class date_scoreboard;
    out_t expected_q[$];
    int   mismatches;
    int   op_count[4];
    int   clamped_count;
    int   replaced_count;

    static function bit is_leap(int y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4) == 0;
    endfunction

    static function int month_length(int m, int y);
      if (m < 1 || m > 12) return 0;
      case (m)
        2: return is_leap(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    static function bit date_valid(int d, int m, int y);
      return y >= FirstYear && y <= LastYear && m >= 1 && m <= 12 &&
             d >= 1 && d <= month_length(m, y);
    endfunction

    // Days from 1.1.1 to 1.1.y.
    static function int days_to_year(int y);
      int p;
      p = (y >= 1) ? y - 1 : 0;
      return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    // Day number counted from 1.1.FirstYear; an invalid date maps to zero.
    static function int serial_of(int d, int m, int y);
      int s;
      if (!date_valid(d, m, y)) return 0;
      s = days_to_year(y) - days_to_year(FirstYear);
      for (int i = 1; i < m; i++) s += month_length(i, y);
      return s + d - 1;
    endfunction

    static function void date_of(int s, output int d, output int m, output int y);
      int len;
      y = FirstYear;
      m = 1;
      // Step whole years, then whole months.
      forever begin
        len = is_leap(y) ? 366 : 365;
        if (s < len || y >= LastYear) break;
        s -= len;
        y++;
      end
      forever begin
        len = month_length(m, y);
        if (s < len || m >= 12) break;
        s -= len;
        m++;
      end
      d = s + 1;
    endfunction

    static function out_t predict_result(in_t item);
      out_t r;
      int a, b, cnt, s, d, m, y, diff;
      r   = '0;
      a   = serial_of(int'(item.day), int'(item.month), int'(item.year));
      cnt = int'(item.day_count);
      case (item.operation)
        OP_ADD, OP_SUB: begin
          if (item.operation == OP_ADD) begin
            s = a + cnt;
            if (s > LastSerial) begin
              s = LastSerial;
              r.out_of_range = 1'b1;
            end
          end else if (cnt > a) begin
            s = 0;
            r.out_of_range = 1'b1;
          end else begin
            s = a - cnt;
          end
          date_of(s, d, m, y);
          r.result_day   = 5'(d);
          r.result_month = 4'(m);
          r.result_year  = 12'(y);
        end
        OP_DIFF: begin
          b = serial_of(int'(item.other_day), int'(item.other_month), int'(item.other_year));
          diff = (a > b) ? a - b : b - a;
          if (diff > DiffCeiling) diff = DiffCeiling;
          r.day_difference = 16'(diff);
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(in_t item);
      out_t want;
      want = predict_result(item);
      expected_q.push_back(want);
      op_count[item.operation]++;
      if (want.out_of_range) clamped_count++;
      if (!date_valid(int'(item.day), int'(item.month), int'(item.year)) ||
          (item.operation == OP_DIFF &&
           !date_valid(int'(item.other_day), int'(item.other_month),
                       int'(item.other_year))))
        replaced_count++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: day %0d month %0d year %0d diff %0d oor %0d",
                   got.result_day, got.result_month, got.result_year,
                   got.day_difference, got.out_of_range);
        return;
      end
      want = expected_q.pop_front();
      if (got.result_day !== want.result_day || got.result_month !== want.result_month ||
          got.result_year !== want.result_year ||
          got.day_difference !== want.day_difference ||
          got.out_of_range !== want.out_of_range) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("mismatch: expected %0d.%0d.%0d diff %0d oor %0d, got %0d.%0d.%0d diff %0d oor %0d",
                   want.result_day, want.result_month, want.result_year,
                   want.day_difference, want.out_of_range,
                   got.result_day, got.result_month, got.result_year,
                   got.day_difference, got.out_of_range);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  bit steady_run = 1'b0;
  int quiet_cycles;
  date_scoreboard sb = new;

  gregorian_date_arithmetic uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Generate the clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at random, except during the steady stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !steady_run && ($urandom_range(99, 0) < 36);
  end

  // Track both channels and end the run if the block goes quiet.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      quiet_cycles++;
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        sb.note_input(in_data_i);
        quiet_cycles = 0;
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        sb.check_result(out_data_o);
        quiet_cycles = 0;
      end
    end
    $display("watchdog: no transaction for %0d cycles", QuietLimit);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic in_t make_item(logic [1:0] op, int d, int m, int y, int cnt,
                                    int od, int om, int oy);
    in_t it;
    it.operation   = op;
    it.day         = 5'(d);
    it.month       = 4'(m);
    it.year        = 12'(y);
    it.day_count   = 16'(cnt);
    it.other_day   = 5'(od);
    it.other_month = 4'(om);
    it.other_year  = 12'(oy);
    return it;
  endfunction

  // Pick a valid date, biased toward the year bounds and the first and last day of a month.
  function automatic void rand_date(output int d, output int m, output int y);
    case ($urandom_range(4, 0))
      0: y = FirstYear;
      1: y = LastYear;
      default: y = $urandom_range(LastYear, FirstYear);
    endcase
    m = $urandom_range(12, 1);
    case ($urandom_range(3, 0))
      0: d = 1;
      1: d = date_scoreboard::month_length(m, y);
      default: d = $urandom_range(date_scoreboard::month_length(m, y), 1);
    endcase
  endfunction

  // Break one field of a date so that it gets replaced.
  function automatic void spoil_date(inout int d, inout int m, inout int y);
    case ($urandom_range(5, 0))
      0: d = 0;
      1: d = date_scoreboard::month_length(m, y) + 1;
      2: m = 0;
      3: m = $urandom_range(15, 13);
      4: y = $urandom_range(FirstYear - 1, 0);
      default: y = $urandom_range(4095, LastYear + 1);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t it;
    int d, m, y, od, om, oy, a, cnt, kind;
    logic [1:0] op;
    kind = $urandom_range(99, 0);
    // Raw bits: every field anywhere in its encoding.
    if (kind < 10) begin
      it.operation   = 2'($urandom);
      it.day         = 5'($urandom);
      it.month       = 4'($urandom);
      it.year        = 12'($urandom);
      it.day_count   = 16'($urandom);
      it.other_day   = 5'($urandom);
      it.other_month = 4'($urandom);
      it.other_year  = 12'($urandom);
      return it;
    end
    rand_date(d, m, y);
    rand_date(od, om, oy);
    op = 2'($urandom_range(OP_DIFF, OP_ADD));
    a  = date_scoreboard::serial_of(d, m, y);
    case ($urandom_range(9, 0))
      0, 1, 2, 3: cnt = $urandom_range(400, 0);
      4, 5: cnt = $urandom_range(65535, 0);
      6: cnt = $urandom_range(LastSerial, 0);
      7: cnt = ((op == OP_SUB) ? a : LastSerial - a) + int'($urandom_range(4, 0)) - 2;
      8: cnt = ($urandom_range(1, 0) == 0) ? 0 : 65535;
      default: cnt = $urandom_range(5000, 0);
    endcase
    if (cnt < 0) cnt = 0;
    if (cnt > 65535) cnt = 65535;
    if (op == OP_DIFF && $urandom_range(9, 0) == 0) begin
      od = d;
      om = m;
      oy = y;
    end
    if (kind < 22) begin
      if ($urandom_range(1, 0) == 0) spoil_date(d, m, y);
      else spoil_date(od, om, oy);
    end
    return make_item(op, d, m, y, cnt, od, om, oy);
  endfunction

  // Present one transaction, after an optional random gap, and hold it until taken.
  task automatic send_item(in_t item);
    int gap = 0;
    if (!steady_run) begin
      while ($urandom_range(99, 0) < 36) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range ends, leap days, clamping, replaced dates, unused code.
    send_item(make_item(OP_ADD, 1, 1, 1970, 0, 1, 1, 1970));
    send_item(make_item(OP_ADD, 31, 12, 2099, 0, 1, 1, 1970));
    send_item(make_item(OP_ADD, 31, 12, 2099, 1, 1, 1, 1970));
    send_item(make_item(OP_ADD, 1, 1, 1970, 65535, 1, 1, 1970));
    send_item(make_item(OP_ADD, 1, 1, 1970, LastSerial, 1, 1, 1970));
    send_item(make_item(OP_SUB, 1, 1, 1970, 1, 1, 1, 1970));
    send_item(make_item(OP_SUB, 31, 12, 2099, 65535, 1, 1, 1970));
    send_item(make_item(OP_SUB, 31, 12, 2099, LastSerial, 1, 1, 1970));
    send_item(make_item(OP_ADD, 28, 2, 2000, 1, 1, 1, 1970));
    send_item(make_item(OP_ADD, 28, 2, 2097, 1, 1, 1, 1970));
    send_item(make_item(OP_SUB, 1, 3, 2000, 1, 1, 1, 1970));
    send_item(make_item(OP_ADD, 31, 12, 1999, 1, 1, 1, 1970));
    send_item(make_item(OP_SUB, 1, 1, 2000, 1, 1, 1, 1970));
    send_item(make_item(OP_ADD, 29, 2, 2001, 5, 1, 1, 1970));
    send_item(make_item(OP_ADD, 0, 6, 2010, 3, 1, 1, 1970));
    send_item(make_item(OP_ADD, 31, 4, 2010, 3, 1, 1, 1970));
    send_item(make_item(OP_ADD, 15, 0, 2010, 3, 1, 1, 1970));
    send_item(make_item(OP_SUB, 15, 13, 2010, 0, 1, 1, 1970));
    send_item(make_item(OP_ADD, 15, 6, 1969, 7, 1, 1, 1970));
    send_item(make_item(OP_ADD, 15, 6, 2100, 7, 1, 1, 1970));
    send_item(make_item(OP_DIFF, 1, 1, 1970, 0, 31, 12, 2099));
    send_item(make_item(OP_DIFF, 31, 12, 2099, 0, 1, 1, 1970));
    send_item(make_item(OP_DIFF, 29, 2, 2024, 0, 29, 2, 2024));
    send_item(make_item(OP_DIFF, 10, 5, 2050, 0, 12, 15, 2050));
    send_item(make_item(OpUnused, 31, 15, 4095, 65535, 31, 15, 4095));
    send_item(make_item(OP_DIFF, 31, 15, 4095, 65535, 31, 15, 4095));
    send_item(make_item(OP_ADD, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Random: mostly valid dates, with a stretch at full rate on both sides.
    for (int i = 0; i < RandomItems; i++) begin
      steady_run = (i >= 500 && i < 750);
      if (i == 1000) drain();
      send_item(random_item());
    end
    steady_run = 1'b0;
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d add, %0d subtract, %0d difference and %0d unused-code transactions",
             sb.op_count[OP_ADD], sb.op_count[OP_SUB], sb.op_count[OP_DIFF],
             sb.op_count[OpUnused]);
    $display("%0d results clamped at the year bounds, %0d with a replaced date, %0d mismatches",
             sb.clamped_count, sb.replaced_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
